/* src/assert_macros.svh */
// Assertion macros for the checker file dckv_checker.
// No dependencies; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* src/dckv_pkg.sv */
// Package for the dual contact key velocity block: sizes, phase codes,
// controller/datapath command and status structs. No dependencies.
package dckv_pkg;

   localparam int NUM_GROUPS         = 7;
   localparam int CHANNELS_PER_GROUP = 16;
   localparam int NUM_KEYS           = NUM_GROUPS * CHANNELS_PER_GROUP;
   localparam int KEY_W              = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   localparam int GROUP_W   = 3;
   localparam int CHANNEL_W = 4;
   localparam int TIME_W    = 32;
   localparam int PHASE_W   = 2;
   localparam int VOL_W     = 17;

   localparam int REQ_DATA_W = 48;   // 41 payload bits padded to bytes
   localparam int RSP_DATA_W = 32;   // 26 payload bits padded to bytes

   localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
   localparam logic [PHASE_W-1:0] PH_HALF = 2'd1;
   localparam logic [PHASE_W-1:0] PH_FULL = 2'd2;

   localparam logic [VOL_W-1:0] VOL_ONE  = 17'h10000;
   localparam logic [VOL_W-1:0] VOL_ZERO = 17'h00000;

   typedef struct packed {
      logic capture;     // latch the accepted beat
      logic read;        // read key state for the latched key
      logic div_start;   // launch the reciprocal divider
      logic commit;      // write back key state and load the result
   } cmd_type;

   typedef struct packed {
      logic need_div;    // held full press: volume must be recomputed
      logic div_done;    // divider quotient is ready
      logic out_free;    // result register can take a new beat
   } sts_type;

endpackage

/* src/dckv_div.sv */
// Restoring divider for the velocity volume: VOL_ONE / divisor, one
// quotient bit per cycle. Uses dckv_pkg.
module dckv_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [dckv_pkg::VOL_W-1:0]  divisor,
   output logic                        done,
   output logic [dckv_pkg::VOL_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(dckv_pkg::VOL_W + 1);

   logic                        busy_ff,  busy_in;
   logic                        done_ff,  done_in;
   logic [CNT_W-1:0]            cnt_ff,   cnt_in;
   logic [dckv_pkg::VOL_W-1:0]  rem_ff,   rem_in;
   logic [dckv_pkg::VOL_W-1:0]  quo_ff,   quo_in;
   logic [dckv_pkg::VOL_W-1:0]  dvs_ff,   dvs_in;
   logic [dckv_pkg::VOL_W:0]    trial;
   logic                        fits;

   // shift in the next dividend bit, subtract when it fits
   assign trial = {rem_ff, quo_ff[dckv_pkg::VOL_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(dckv_pkg::VOL_W);
         rem_in  = '0;
         quo_in  = dckv_pkg::VOL_ONE;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? dckv_pkg::VOL_W'(trial - {1'b0, dvs_ff})
                       : trial[dckv_pkg::VOL_W-1:0];
         quo_in = {quo_ff[dckv_pkg::VOL_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* src/dckv_ctrl.sv */
// Controller state machine: sequences capture, key read, evaluate,
// optional divide and write-back. Uses dckv_pkg command/status structs.
module dckv_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  dckv_pkg::sts_type sts,
   output dckv_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_EVAL  = 5'b00100,
      S_DIV   = 5'b01000,
      S_WRITE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

/* src/dckv_datapath.sv */
// Datapath: beat capture, per-key state memories with valid bits, phase
// update logic, divider and result register. Uses dckv_pkg and dckv_div.
module dckv_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  dckv_pkg::cmd_type                cmd,
   output dckv_pkg::sts_type                sts,
   input  logic [dckv_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dckv_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int ENTRY_W = 2 * dckv_pkg::VOL_W + dckv_pkg::PHASE_W;
   localparam int PAD_W   = dckv_pkg::RSP_DATA_W - dckv_pkg::GROUP_W
                            - dckv_pkg::CHANNEL_W - dckv_pkg::PHASE_W - dckv_pkg::VOL_W;

   // latched beat
   logic [dckv_pkg::GROUP_W-1:0]   grp_ff;
   logic [dckv_pkg::CHANNEL_W-1:0] ch_ff;
   logic                           up_ff;
   logic                           lo_ff;
   logic [dckv_pkg::TIME_W-1:0]    now_ff;

   // key state memories: press start time, and {elapsed, volume, phase}
   logic [dckv_pkg::TIME_W-1:0] start_mem [dckv_pkg::NUM_KEYS];
   logic [ENTRY_W-1:0]          key_mem   [dckv_pkg::NUM_KEYS];
   logic                        valid_ff  [dckv_pkg::NUM_KEYS];

   logic [dckv_pkg::TIME_W-1:0] start_rd_ff;
   logic [ENTRY_W-1:0]          key_rd_ff;
   logic                        vld_rd_ff;

   logic [7:0]                      idx_full;
   logic [dckv_pkg::KEY_W-1:0]      idx;
   logic                            in_range;
   logic [dckv_pkg::PHASE_W-1:0]    cur_phase;
   logic [dckv_pkg::VOL_W-1:0]      cur_vol;
   logic [dckv_pkg::VOL_W-1:0]      cur_elap;
   logic [dckv_pkg::TIME_W-1:0]     diff;
   logic [dckv_pkg::VOL_W-1:0]      diff_sat;
   logic [dckv_pkg::PHASE_W-1:0]    next_phase;
   logic [dckv_pkg::VOL_W-1:0]      next_vol;
   logic [dckv_pkg::VOL_W-1:0]      next_elap;
   logic                            wr_start;
   logic                            need_div;
   logic                            div_done;
   logic [dckv_pkg::VOL_W-1:0]      div_quo;
   logic [dckv_pkg::PHASE_W-1:0]    out_phase;
   logic [dckv_pkg::VOL_W-1:0]      out_vol;

   logic                            rsp_valid_ff;
   logic [dckv_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         grp_ff <= req_tdata[2:0];
         ch_ff  <= req_tdata[6:3];
         up_ff  <= req_tdata[7];
         lo_ff  <= req_tdata[8];
         now_ff <= req_tdata[40:9];
      end
   end

   assign idx_full = 8'(grp_ff) * 8'(dckv_pkg::CHANNELS_PER_GROUP) + 8'(ch_ff);
   assign idx      = idx_full[dckv_pkg::KEY_W-1:0];
   assign in_range = (32'(grp_ff) < 32'(dckv_pkg::NUM_GROUPS)) &&
                     (32'(ch_ff) < 32'(dckv_pkg::CHANNELS_PER_GROUP));

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         start_rd_ff <= start_mem[idx];
         key_rd_ff   <= key_mem[idx];
         vld_rd_ff   <= valid_ff[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && in_range) begin
         if (wr_start) begin
            start_mem[idx] <= now_ff;
         end
         key_mem[idx] <= {next_elap, next_vol, next_phase};
      end
   end

   // never-written keys read as idle with zero volume
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < dckv_pkg::NUM_KEYS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (cmd.commit && in_range) begin
         valid_ff[idx] <= 1'b1;
      end
   end

   assign cur_phase = vld_rd_ff ? key_rd_ff[dckv_pkg::PHASE_W-1:0] : dckv_pkg::PH_IDLE;
   assign cur_vol   = vld_rd_ff ? key_rd_ff[dckv_pkg::PHASE_W +: dckv_pkg::VOL_W]
                                : dckv_pkg::VOL_ZERO;
   assign cur_elap  = key_rd_ff[dckv_pkg::PHASE_W + dckv_pkg::VOL_W +: dckv_pkg::VOL_W];

   // any press longer than 65535 ms gives volume 0, so saturate there
   assign diff     = now_ff - start_rd_ff;
   assign diff_sat = (|diff[31:16]) ? dckv_pkg::VOL_ONE : {1'b0, diff[15:0]};

   assign need_div = in_range && (cur_phase == dckv_pkg::PH_FULL) && up_ff && lo_ff;

   always_comb begin
      next_phase = cur_phase;
      next_vol   = cur_vol;
      next_elap  = cur_elap;
      wr_start   = 1'b0;
      priority if (cur_phase == dckv_pkg::PH_HALF) begin
         if (!up_ff && !lo_ff) begin
            next_phase = dckv_pkg::PH_IDLE;
         end else if (up_ff && lo_ff) begin
            next_phase = dckv_pkg::PH_FULL;
            next_elap  = diff_sat;
         end
      end else if (cur_phase == dckv_pkg::PH_FULL) begin
         if (!up_ff && !lo_ff) begin
            next_phase = dckv_pkg::PH_IDLE;
            next_vol   = dckv_pkg::VOL_ZERO;
         end else if (up_ff && !lo_ff) begin
            next_phase = dckv_pkg::PH_HALF;
            next_vol   = dckv_pkg::VOL_ZERO;
         end else if (up_ff && lo_ff) begin
            next_vol = div_quo;
         end
      end else begin
         if (up_ff) begin
            next_phase = dckv_pkg::PH_HALF;
            wr_start   = 1'b1;
         end
      end
   end

   dckv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (cur_elap + 1'b1),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign out_phase = in_range ? next_phase : dckv_pkg::PH_IDLE;
   assign out_vol   = in_range ? next_vol   : dckv_pkg::VOL_ZERO;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= {PAD_W'(0), out_vol, out_phase, ch_ff, grp_ff};
      end
   end

   assign sts.need_div = need_div;
   assign sts.div_done = div_done;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* src/dual_contact_key_velocity.sv */
// Dual contact key velocity sensing: one scan beat in, one key status beat
// out. The request channel (req_t*) carries a key address, the two contact
// levels and a millisecond time stamp; the response channel (rsp_t*) returns
// the key address, its phase after the update and its Q1.16 volume.
// Each key runs idle -> half (upper contact) -> full (both contacts); a held
// full press reports volume floor(65536 / (1 + full time - start time)).
// Keys outside the configured groups/channels change nothing and report
// phase idle, volume 0.
// Timing: one beat is worked on at a time. After accept the beat passes
// the read, evaluate and write-back states, with a divide state between
// when a held full press runs the 17-step reciprocal divider (one quotient
// bit per cycle). req_tready rises with rsp_tvalid, so a new beat can be
// taken even while the previous response still waits for rsp_tready.
// If the receiver stalls, the response register holds the beat and the
// next item waits at write-back until the register frees.
// Reset (synchronous, active high) marks every key idle with volume 0
// through per-key valid bits; no clearing pass is needed, so the block is
// ready in the first cycle after reset.
module dual_contact_key_velocity (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [2:0] key_group, [6:3] key_channel, [7] upper_contact,
   // [8] lower_contact, [40:9] now_ms, [47:41] zero
   input  logic [dckv_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [2:0] out_group, [6:3] out_channel, [8:7] key_phase,
   // [25:9] key_volume, [31:26] zero
   output logic [dckv_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   dckv_pkg::cmd_type cmd;
   dckv_pkg::sts_type sts;

   // state machine: sequencing and the input handshake
   dckv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // key memories, phase logic, divider and response register
   dckv_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* src/dckv_checker.sv */
// Port-level checker for dual_contact_key_velocity, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module dckv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled response stays up
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // one beat in flight: ready drops right after an accept
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // the unused phase code never shows
   `ASSERT_IMPLY(a_phase_code, clock, reset, rsp_tvalid, rsp_tdata[8:7] != 2'b11)

   // an idle key never carries volume
   `ASSERT_IMPLY(a_idle_silent, clock, reset,
      rsp_tvalid && (rsp_tdata[8:7] == 2'b00), rsp_tdata[25:9] == 17'd0)

endmodule

bind dual_contact_key_velocity dckv_checker u_dckv_checker (.*);
